/* design/generational_handle_slot_table_macros.svh */
// Assertion macros for the generational handle slot table checker.
// Depends on clk and arst_n being visible where the macros are used.
`ifndef GENERATIONAL_HANDLE_SLOT_TABLE_MACROS_SVH
`define GENERATIONAL_HANDLE_SLOT_TABLE_MACROS_SVH

// same-cycle implication
`define GHST_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("slot table check failed");

// next-cycle implication
`define GHST_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("slot table check failed");

`endif

/* design/ghst_pkg.sv */
// Shared constants and codes for the generational handle slot table.
// No dependencies.
package ghst_pkg;

	localparam int MAX_SLOTS    = 64;
	localparam int TAG_BITS     = 32;
	localparam int SLOT_W       = $clog2(MAX_SLOTS);
	localparam int ACTIVE_W     = 7;
	localparam int ACTIVE_RESET = 64;
	localparam int IDX_IN_W     = 8;
	localparam int IN_TAG_W     = 32;
	localparam int RES_IDX_W    = 6;
	localparam int RES_TAG_W    = 32;
	localparam int CNT_W        = ($clog2(MAX_SLOTS + 1) > IDX_IN_W + 1) ?
	                              $clog2(MAX_SLOTS + 1) : IDX_IN_W + 1;
	localparam int CMP_W        = (TAG_BITS > IN_TAG_W) ? TAG_BITS : IN_TAG_W;
	localparam int S_TDATA_W    = ((IDX_IN_W + IN_TAG_W + 7) / 8) * 8;
	localparam int M_TDATA_W    = ((RES_IDX_W + RES_TAG_W + 7) / 8) * 8;

	typedef enum logic [1:0] {
		MODE_CREATE  = 2'd0,
		MODE_LOOKUP  = 2'd1,
		MODE_DESTROY = 2'd2,
		MODE_NONE    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_STALE = 2'd3
	} status_t;

endpackage

/* design/generational_handle_slot_table.sv */
// Generational handle slot table: allocates, checks and frees slot handles.
// Depends on ghst_pkg. Tags live in a one-port-read synchronous memory.
//
// channel   dir  handshake          payload
// cfg       in   cfg_we             cfg_wdata = active_slots
// s (req)   in   s_tvalid/s_tready  tuser = mode, tdata = slot_index, handle_tag
// m (resp)  out  m_tvalid/m_tready  tuser = status, tdata = result_index, result_tag
//
// Per request: tag memory read on acceptance, then check and write-back in
// S_EXEC, which also loads the response register; one request at a time.
// The response register frees the input side; a held response stalls the
// write-back cycle only. No clearing pass after reset: the used bitmap is in
// flops and a tag is read only for a slot marked used.
module generational_handle_slot_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ghst_pkg::ACTIVE_W-1:0]     cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [ghst_pkg::S_TDATA_W-1:0]    s_tdata,  // slot_index, handle_tag
	input  logic [1:0]                        s_tuser,  // mode
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [ghst_pkg::M_TDATA_W-1:0]    m_tdata,  // result_index, result_tag, pad
	output logic [1:0]                        m_tuser   // status
);

	typedef enum logic {S_IDLE, S_EXEC} state_t;

	state_t                               state_q;
	logic [ghst_pkg::ACTIVE_W-1:0]        active_q;
	logic [ghst_pkg::MAX_SLOTS-1:0]       used_q;
	logic [ghst_pkg::TAG_BITS-1:0]        next_tag_q;
	logic                                 m_tvalid_q;
	logic [ghst_pkg::M_TDATA_W-1:0]       m_tdata_q;
	logic [1:0]                           m_tuser_q;

	ghst_pkg::mode_t                      mode_s1;
	logic [ghst_pkg::IDX_IN_W-1:0]        idx_s1;
	logic [ghst_pkg::IN_TAG_W-1:0]        tag_s1;
	logic [ghst_pkg::TAG_BITS-1:0]        rd_tag_s2;

	logic [ghst_pkg::TAG_BITS-1:0]        tag_mem [ghst_pkg::MAX_SLOTS];

	logic                                 accept;
	logic                                 exec_go;
	logic [ghst_pkg::CNT_W-1:0]           eff;
	logic [ghst_pkg::MAX_SLOTS-1:0]       free_vec;
	logic                                 found;
	logic [ghst_pkg::SLOT_W-1:0]          free_idx;
	logic [ghst_pkg::SLOT_W-1:0]          slot;
	logic                                 in_range;
	logic                                 tag_hit;
	ghst_pkg::status_t                    res_status;
	logic [ghst_pkg::SLOT_W-1:0]          res_slot;
	logic [ghst_pkg::TAG_BITS-1:0]        res_tag;
	logic                                 mem_we;
	logic [ghst_pkg::SLOT_W-1:0]          mem_waddr;
	logic [ghst_pkg::TAG_BITS-1:0]        mem_wdata;
	logic                                 set_used;
	logic                                 clr_used;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign exec_go  = (state_q == S_EXEC) && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	assign eff = (active_q > ghst_pkg::ACTIVE_W'(ghst_pkg::MAX_SLOTS)) ?
	             ghst_pkg::CNT_W'(ghst_pkg::MAX_SLOTS) : ghst_pkg::CNT_W'(active_q);

	always_comb begin
		for (int i = 0; i < ghst_pkg::MAX_SLOTS; i++) begin
			free_vec[i] = !used_q[i] && (ghst_pkg::CNT_W'(i) < eff);
		end
	end

	assign found = |free_vec;

	// lowest free slot wins
	always_comb begin
		free_idx = '0;
		for (int i = ghst_pkg::MAX_SLOTS - 1; i >= 0; i--) begin
			if (free_vec[i]) begin
				free_idx = ghst_pkg::SLOT_W'(i);
			end
		end
	end

	assign slot     = idx_s1[ghst_pkg::SLOT_W-1:0];
	assign in_range = ghst_pkg::CNT_W'(idx_s1) < eff;
	assign tag_hit  = used_q[slot] &&
	                  (ghst_pkg::CMP_W'(rd_tag_s2) == ghst_pkg::CMP_W'(tag_s1));

	always_comb begin
		res_status = ghst_pkg::ST_OK;
		res_slot   = '0;
		res_tag    = '0;
		mem_we     = 1'b0;
		mem_waddr  = slot;
		mem_wdata  = '0;
		set_used   = 1'b0;
		clr_used   = 1'b0;
		unique case (mode_s1)
			ghst_pkg::MODE_CREATE: begin
				if (found) begin
					res_slot  = free_idx;
					res_tag   = next_tag_q;
					mem_we    = exec_go;
					mem_waddr = free_idx;
					mem_wdata = next_tag_q;
					set_used  = exec_go;
				end else begin
					res_status = ghst_pkg::ST_FULL;
				end
			end
			ghst_pkg::MODE_LOOKUP, ghst_pkg::MODE_DESTROY: begin
				priority if (!in_range) begin
					res_status = ghst_pkg::ST_RANGE;
				end else if (!tag_hit) begin
					res_status = ghst_pkg::ST_STALE;
				end else begin
					res_slot = slot;
					res_tag  = rd_tag_s2;
					if (mode_s1 == ghst_pkg::MODE_DESTROY) begin
						mem_we   = exec_go;
						clr_used = exec_go;
					end
				end
			end
			ghst_pkg::MODE_NONE: begin
				res_status = ghst_pkg::ST_OK;
			end
			default: begin
				res_status = ghst_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tag_mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_tag_s2 <= tag_mem[s_tdata[ghst_pkg::SLOT_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= ghst_pkg::mode_t'(s_tuser);
			idx_s1  <= s_tdata[ghst_pkg::IDX_IN_W-1:0];
			tag_s1  <= s_tdata[ghst_pkg::IDX_IN_W +: ghst_pkg::IN_TAG_W];
		end
		if (exec_go && (mode_s1 != ghst_pkg::MODE_NONE)) begin
			m_tuser_q <= res_status;
			m_tdata_q <= ghst_pkg::M_TDATA_W'({ghst_pkg::RES_TAG_W'(res_tag),
			                                   ghst_pkg::RES_IDX_W'(res_slot)});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ghst_pkg::ACTIVE_W'(ghst_pkg::ACTIVE_RESET);
		end else if (cfg_we) begin
			active_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			used_q     <= '0;
			next_tag_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (exec_go && (mode_s1 != ghst_pkg::MODE_NONE)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_go) begin
						state_q <= S_IDLE;
						if (set_used) begin
							used_q[free_idx] <= 1'b1;
							next_tag_q       <= next_tag_q + ghst_pkg::TAG_BITS'(1);
						end
						if (clr_used) begin
							used_q[slot] <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* design/ghst_checker.sv */
// Port-level checks for the generational handle slot table, bound to the top.
// Depends on ghst_pkg and generational_handle_slot_table_macros.svh.
`include "generational_handle_slot_table_macros.svh"

module ghst_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [1:0]                        s_tuser,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [ghst_pkg::M_TDATA_W-1:0]    m_tdata,
	input logic [1:0]                        m_tuser
);

	`GHST_ASSERT_NEXT(a_resp_held, m_tvalid && !m_tready, m_tvalid)
	`GHST_ASSERT_NEXT(a_resp_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
	`GHST_ASSERT_NOW(a_fail_zero, m_tvalid && (m_tuser != ghst_pkg::ST_OK), m_tdata == '0)
	`GHST_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)

endmodule

bind generational_handle_slot_table ghst_checker u_ghst_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

/* verif/tb_generational_handle_slot_table.sv */
`timescale 1ns / 1ps
// Testbench for generational_handle_slot_table: directed and random create, lookup and destroy
// requests over several active slot counts, checked against an in-bench table predictor.
// Depends on ghst_pkg and the slot table RTL.
module tb_generational_handle_slot_table;

	localparam int LIMIT       = 200000;
	localparam int HOLD_CYCLES = 120;
	localparam int SETTLE      = 8;
	localparam int PHASES      = 10;
	localparam int PH_ITEMS    = 58;

	typedef struct packed {
		ghst_pkg::status_t              st;
		logic [ghst_pkg::RES_IDX_W-1:0] idx;
		logic [ghst_pkg::RES_TAG_W-1:0] tag;
	} answer_t;

	class handle_table_model;
		localparam int MAX_PRINTS = 30;
		bit                            used[ghst_pkg::MAX_SLOTS];
		logic [ghst_pkg::TAG_BITS-1:0] stamp[ghst_pkg::MAX_SLOTS];
		logic [ghst_pkg::TAG_BITS-1:0] tag_ctr;
		logic [ghst_pkg::ACTIVE_W-1:0] active;
		answer_t                       due[$];
		int                            errors;
		int                            seen[4];

		function new();
			foreach (used[i]) begin
				used[i] = 1'b0;
				stamp[i] = '0;
			end
			foreach (seen[i])
				seen[i] = 0;
			tag_ctr = '0;
			active = ghst_pkg::ACTIVE_W'(ghst_pkg::ACTIVE_RESET);
			errors = 0;
		endfunction

		function int usable();
			return (active > ghst_pkg::MAX_SLOTS) ? ghst_pkg::MAX_SLOTS : int'(active);
		endfunction

		task flag(string msg);
			errors++;
			if (errors <= MAX_PRINTS)
				$display("[%0t] mismatch: %s", $time, msg);
		endtask

		// predicted answer for one accepted request; advances the table
		function void take_request(ghst_pkg::mode_t m, logic [ghst_pkg::IDX_IN_W-1:0] idx,
				logic [ghst_pkg::IN_TAG_W-1:0] tag);
			answer_t                     a;
			int                          n;
			int                          hit;
			logic [ghst_pkg::SLOT_W-1:0] s;
			n = usable();
			hit = -1;
			s = idx[ghst_pkg::SLOT_W-1:0];
			a = '0;
			a.st = ghst_pkg::ST_OK;
			case (m)
			ghst_pkg::MODE_CREATE: begin
				for (int i = 0; i < n; i++)
					if (!used[i] && hit < 0)
						hit = i;
				if (hit < 0) begin
					a.st = ghst_pkg::ST_FULL;
				end else begin
					used[hit] = 1'b1;
					stamp[hit] = tag_ctr;
					tag_ctr = tag_ctr + ghst_pkg::TAG_BITS'(1);
					a.idx = ghst_pkg::RES_IDX_W'(hit);
					a.tag = stamp[hit];
				end
				due = {due, a};
			end
			ghst_pkg::MODE_LOOKUP, ghst_pkg::MODE_DESTROY: begin
				if (int'(idx) >= n) begin
					a.st = ghst_pkg::ST_RANGE;
				end else if (!used[s] || stamp[s] != tag) begin
					a.st = ghst_pkg::ST_STALE;
				end else begin
					a.idx = idx[ghst_pkg::RES_IDX_W-1:0];
					a.tag = stamp[s];
					if (m == ghst_pkg::MODE_DESTROY) begin
						used[s] = 1'b0;
						stamp[s] = '0;
					end
				end
				due = {due, a};
			end
			default: ;
			endcase
		endfunction

		task match_answer(logic [1:0] st, logic [ghst_pkg::RES_IDX_W-1:0] idx,
				logic [ghst_pkg::RES_TAG_W-1:0] tag);
			answer_t a;
			if (due.size() == 0) begin
				flag($sformatf("response status %0d with no request outstanding", st));
			end else begin
				a = due.pop_front();
				seen[int'(a.st)]++;
				if (st !== a.st)
					flag($sformatf("status %0d, expected %s", st, a.st.name()));
				if (idx !== a.idx)
					flag($sformatf("index %0d, expected %0d", idx, a.idx));
				if (tag !== a.tag)
					flag($sformatf("tag %h, expected %h", tag, a.tag));
			end
		endtask

		task leftover();
			if (due.size() != 0)
				flag($sformatf("%0d responses never arrived", due.size()));
		endtask
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [ghst_pkg::ACTIVE_W-1:0]  cfg_wdata;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [ghst_pkg::S_TDATA_W-1:0] s_tdata;  // slot_index, handle_tag
	logic [1:0]                     s_tuser;  // mode
	logic                           m_tvalid;
	logic                           m_tready;
	logic [ghst_pkg::M_TDATA_W-1:0] m_tdata;  // result_index, result_tag, pad
	logic [1:0]                     m_tuser;  // status

	bit calm;
	bit hold_ask;
	int stall_left;
	int cycle_cnt;
	int item_cnt;
	int ignored_cnt;
	int settings_cnt;
	int ph_active[PHASES] = '{127, 2, 64, 5, 1, 33, 0, 100, 17, 64};
	int ph_create[PHASES] = '{85, 50, 90, 50, 50, 60, 40, 45, 50, 45};

	handle_table_model tbl = new();

	generational_handle_slot_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_req(ghst_pkg::mode_t m, logic [ghst_pkg::IDX_IN_W-1:0] idx,
			logic [ghst_pkg::IN_TAG_W-1:0] tag);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 99) < 20)
			gap = $urandom_range(1, 9);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= m;
		s_tdata <= {tag, idx};
		do @(posedge clk); while (!s_tready);
		tbl.take_request(m, idx, tag);
		if (m == ghst_pkg::MODE_NONE)
			ignored_cnt++;
		else
			item_cnt++;
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (tbl.due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_active(logic [ghst_pkg::ACTIVE_W-1:0] v);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		tbl.active = v;
		settings_cnt++;
	endtask

	// creates by percentage; else mostly well-formed handles taken from live slots, the rest near misses and noise
	task automatic random_req(int create_pct);
		int                            live[$];
		int                            n;
		int                            pick;
		int                            r;
		logic [ghst_pkg::IN_TAG_W-1:0] t;
		n = tbl.usable();
		for (int i = 0; i < n; i++)
			if (tbl.used[i])
				live = {live, i};
		r = $urandom_range(0, 99);
		if (r < create_pct) begin
			send_req(ghst_pkg::MODE_CREATE, ghst_pkg::IDX_IN_W'($urandom), $urandom);
		end else begin
			r = $urandom_range(0, 99);
			if (live.size() != 0 && r < 75) begin
				pick = live[$urandom_range(0, live.size() - 1)];
				send_req(r < 45 ? ghst_pkg::MODE_LOOKUP : ghst_pkg::MODE_DESTROY,
					ghst_pkg::IDX_IN_W'(pick), tbl.stamp[pick]);
			end else if (r < 87) begin
				pick = $urandom_range(0, ghst_pkg::MAX_SLOTS - 1);
				t = tbl.stamp[pick];
				if ($urandom_range(0, 3) != 0)
					t = t ^ (32'd1 << $urandom_range(0, 31));
				send_req($urandom_range(0, 1) ? ghst_pkg::MODE_LOOKUP : ghst_pkg::MODE_DESTROY,
					ghst_pkg::IDX_IN_W'(pick), t);
			end else if (r < 97) begin
				send_req($urandom_range(0, 1) ? ghst_pkg::MODE_LOOKUP : ghst_pkg::MODE_DESTROY,
					ghst_pkg::IDX_IN_W'($urandom_range(0, 255)), $urandom);
			end else begin
				send_req(ghst_pkg::MODE_NONE, ghst_pkg::IDX_IN_W'($urandom_range(0, 255)),
					$urandom);
			end
		end
	endtask

	// receiver: random stall bursts, one long hold on request
	initial begin
		m_tready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_ask) begin
				hold_ask = 1'b0;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && !calm && $urandom_range(0, 99) < 15) begin
				stall_left = $urandom_range(1, 9);
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			tbl.match_answer(m_tuser, m_tdata[ghst_pkg::RES_IDX_W-1:0],
				m_tdata[ghst_pkg::RES_IDX_W +: ghst_pkg::RES_TAG_W]);

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles, %0d responses outstanding", LIMIT,
			tbl.due.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int target;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = ghst_pkg::MODE_CREATE;
		calm = 1'b0;
		hold_ask = 1'b0;
		item_cnt = 0;
		ignored_cnt = 0;
		settings_cnt = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset count of 64 slots
		send_req(ghst_pkg::MODE_LOOKUP, 8'd0, 32'd0);
		send_req(ghst_pkg::MODE_CREATE, 8'hFF, 32'hFFFF_FFFF);
		send_req(ghst_pkg::MODE_LOOKUP, 8'd0, 32'd0);
		send_req(ghst_pkg::MODE_LOOKUP, 8'd0, 32'd1);
		send_req(ghst_pkg::MODE_LOOKUP, 8'd64, 32'd0);
		send_req(ghst_pkg::MODE_DESTROY, 8'hFF, 32'hFFFF_FFFF);
		send_req(ghst_pkg::MODE_CREATE, 8'd0, 32'd0);
		send_req(ghst_pkg::MODE_DESTROY, 8'd0, 32'd0);
		send_req(ghst_pkg::MODE_DESTROY, 8'd0, 32'd0);
		send_req(ghst_pkg::MODE_LOOKUP, 8'd0, 32'd0);     // freed slot, tag cleared to zero
		send_req(ghst_pkg::MODE_CREATE, 8'd0, 32'd0);
		send_req(ghst_pkg::MODE_NONE, 8'd5, 32'h0000_1234);
		send_req(ghst_pkg::MODE_LOOKUP, 8'd63, 32'd0);
		send_req(ghst_pkg::MODE_LOOKUP, 8'd1, 32'hFFFF_FFFF);
		// no usable slots
		set_active(7'd0);
		send_req(ghst_pkg::MODE_CREATE, 8'd0, 32'd0);
		send_req(ghst_pkg::MODE_LOOKUP, 8'd0, 32'd2);
		send_req(ghst_pkg::MODE_DESTROY, 8'd1, 32'd1);
		// one slot; slot 1 stays allocated but hidden
		set_active(7'd1);
		send_req(ghst_pkg::MODE_CREATE, 8'd0, 32'd0);
		send_req(ghst_pkg::MODE_LOOKUP, 8'd1, 32'd1);
		send_req(ghst_pkg::MODE_DESTROY, 8'd0, 32'd2);
		send_req(ghst_pkg::MODE_CREATE, 8'd0, 32'd0);
		// count above the table size saturates; hidden slot is back
		set_active(7'd127);
		send_req(ghst_pkg::MODE_LOOKUP, 8'd1, 32'd1);
		send_req(ghst_pkg::MODE_LOOKUP, 8'd64, 32'd0);

		for (int p = 0; p < PHASES; p++) begin
			set_active(ghst_pkg::ACTIVE_W'(ph_active[p]));
			calm = (p == PHASES - 1);
			if (p == 2)
				hold_ask = 1'b1;
			target = item_cnt + PH_ITEMS;
			while (item_cnt < target) begin
				random_req(ph_create[p]);
				if (p == 5 && item_cnt == target - PH_ITEMS / 2)
					drain();
			end
		end

		drain();
		tbl.leftover();
		$display("ran %0d requests (%0d ignored) over %0d slot count settings",
			item_cnt, ignored_cnt, settings_cnt);
		$display("answers: ok %0d, full %0d, out of range %0d, stale %0d",
			tbl.seen[ghst_pkg::ST_OK], tbl.seen[ghst_pkg::ST_FULL],
			tbl.seen[ghst_pkg::ST_RANGE], tbl.seen[ghst_pkg::ST_STALE]);
		if (tbl.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* files.f */
+incdir+design
design/ghst_pkg.sv
design/generational_handle_slot_table.sv
design/ghst_checker.sv
verif/tb_generational_handle_slot_table.sv
